// ===== src/flash_sample_accumulate_average_core_macros.svh =====
// Assertion macros for the flash accumulate and average core.
// Taken in by the files that assert; no dependencies.
`ifndef FLASH_SAMPLE_ACCUMULATE_AVERAGE_CORE_MACROS_SVH
`define FLASH_SAMPLE_ACCUMULATE_AVERAGE_CORE_MACROS_SVH

`ifndef ASSERT_OFF

`define FSAA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`define FSAA_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`else

`define FSAA_ASSERT(label, clk, rst_n, prop, msg)

`define FSAA_ASSERT_NR(label, clk, prop, msg)

`endif

`endif

// ===== src/fsaa_pkg.sv =====
// Shared constants, types and lookup functions of the flash accumulate core.
// No dependencies.
package fsaa_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int OUT_W           = 16;
  localparam int ROW_W           = 24;
  localparam int CNT_W           = 7;
  localparam int PTS_W           = 8;
  localparam int CFG_W           = 8;
  localparam int CFG_IDX_W       = 2;
  localparam int SEL_W           = 2;
  localparam int SHIFT_W         = 3;
  localparam int DIV_STEPS       = ROW_W;
  localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_ACCUM_SELECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_ENABLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EM_POINTS    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAIN,
    ST_REF,
    ST_DARK,
    ST_COUNT,
    ST_SUB,
    ST_ROW,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic in_valid;
    logic dark_en;
    logic point_last;
    logic row_last;
    logic div_last;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic in_ready;
    logic do_main;
    logic do_ref;
    logic do_dark;
    logic do_count;
    logic do_sub;
    logic do_row;
    logic do_div;
    logic do_out;
  } ctl_t;

  function automatic logic [CNT_W:0] flash_target(input logic [SEL_W-1:0] sel);
    logic [CNT_W:0] t;
    unique case (sel)
      2'd0: t = 8'd8;
      2'd1: t = 8'd32;
      2'd2: t = 8'd64;
      2'd3: t = 8'd128;
      default: t = 8'd8;
    endcase
    return t;
  endfunction

  function automatic logic [SHIFT_W-1:0] flash_shift(input logic [SEL_W-1:0] sel);
    logic [SHIFT_W-1:0] s;
    unique case (sel)
      2'd0: s = 3'd3;
      2'd1: s = 3'd5;
      2'd2: s = 3'd6;
      2'd3: s = 3'd7;
      default: s = 3'd3;
    endcase
    return s;
  endfunction

endpackage

// ===== src/fsaa_if.sv =====
// Valid/ready channel interfaces for flash transactions and point results.
// Depends on fsaa_pkg.
interface fsaa_in_if #(
  parameter int SAMPLE_BITS = fsaa_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] main_raw;
  logic signed [SAMPLE_BITS-1:0] ref_raw;
  logic signed [SAMPLE_BITS-1:0] dark_raw;
  logic                          restart;

  modport source (output valid, main_raw, ref_raw, dark_raw, restart, input ready);
  modport sink   (input valid, main_raw, ref_raw, dark_raw, restart, output ready);
endinterface

interface fsaa_out_if;
  logic                             valid;
  logic                             ready;
  logic [fsaa_pkg::OUT_W-1:0]       point_main;
  logic [fsaa_pkg::OUT_W-1:0]       point_ref;
  logic                             row_done;
  logic [fsaa_pkg::OUT_W-1:0]       row_ref_avg;
  logic                             main_underflow;

  modport source (output valid, point_main, point_ref, row_done, row_ref_avg,
                  main_underflow, input ready);
  modport sink   (input valid, point_main, point_ref, row_done, row_ref_avg,
                  main_underflow, output ready);
endinterface

// ===== src/fsaa_alu.sv =====
// Shared add/subtract unit with carry-out (borrow on subtract).
// No dependencies.
module fsaa_alu #(
  parameter int W = 25
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] res,
  output logic         carry
);

  assign {carry, res} = sub ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, b});

endmodule

// ===== src/fsaa_ctrl.sv =====
// Sequencer stepping one flash transaction through the shared adder.
// Depends on fsaa_pkg.
module fsaa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  fsaa_pkg::sts_t sts,
  output fsaa_pkg::ctl_t ctl
);

  fsaa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsaa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fsaa_pkg::ST_IDLE: begin
        if (sts.in_valid) state_nxt = fsaa_pkg::ST_MAIN;
      end
      fsaa_pkg::ST_MAIN: state_nxt = fsaa_pkg::ST_REF;
      fsaa_pkg::ST_REF: begin
        state_nxt = sts.dark_en ? fsaa_pkg::ST_DARK : fsaa_pkg::ST_COUNT;
      end
      fsaa_pkg::ST_DARK: state_nxt = fsaa_pkg::ST_COUNT;
      fsaa_pkg::ST_COUNT: begin
        state_nxt = sts.point_last ? fsaa_pkg::ST_SUB : fsaa_pkg::ST_IDLE;
      end
      fsaa_pkg::ST_SUB: state_nxt = fsaa_pkg::ST_ROW;
      fsaa_pkg::ST_ROW: begin
        state_nxt = sts.row_last ? fsaa_pkg::ST_DIV : fsaa_pkg::ST_OUT;
      end
      fsaa_pkg::ST_DIV: begin
        if (sts.div_last) state_nxt = fsaa_pkg::ST_OUT;
      end
      fsaa_pkg::ST_OUT: begin
        if (sts.out_free) state_nxt = fsaa_pkg::ST_IDLE;
      end
      default: state_nxt = fsaa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_r)
      fsaa_pkg::ST_IDLE:  ctl.in_ready = 1'b1;
      fsaa_pkg::ST_MAIN:  ctl.do_main  = 1'b1;
      fsaa_pkg::ST_REF:   ctl.do_ref   = 1'b1;
      fsaa_pkg::ST_DARK:  ctl.do_dark  = 1'b1;
      fsaa_pkg::ST_COUNT: ctl.do_count = 1'b1;
      fsaa_pkg::ST_SUB:   ctl.do_sub   = 1'b1;
      fsaa_pkg::ST_ROW:   ctl.do_row   = 1'b1;
      fsaa_pkg::ST_DIV:   ctl.do_div   = 1'b1;
      fsaa_pkg::ST_OUT:   ctl.do_out   = sts.out_free;
      default:            ctl          = '0;
    endcase
  end

endmodule

// ===== src/flash_sample_accumulate_average_core.sv =====
// Flash accumulate and average core: per-point boxcar sums, optional dark subtraction,
// row reference mean by a 24-step restoring divide on the shared adder.
// A new flash is accepted only with the sequencer back in idle, after the shared adder
// has summed the last one and, at a point end, its result has been registered; that
// register waits while an unread result is held, so an output stall holds the input.
// Reset: synchronous active-low; clears sums, counters, output valid, resets config.
`include "flash_sample_accumulate_average_core_macros.svh"
module flash_sample_accumulate_average_core #(
  parameter int SAMPLE_BITS = fsaa_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  fsaa_in_if.sink                          in_ch,
  fsaa_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [fsaa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fsaa_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int SUM_BITS = SAMPLE_BITS + 7;
  localparam int ALU_W    = ((SUM_BITS > fsaa_pkg::ROW_W) ? SUM_BITS : fsaa_pkg::ROW_W) + 1;
  localparam int SHIFT_AMT_W = fsaa_pkg::SHIFT_W;

  fsaa_pkg::sts_t sts;
  fsaa_pkg::ctl_t ctl;

  logic [fsaa_pkg::SEL_W-1:0]     accum_sel_r;
  logic                           dark_en_r;
  logic [fsaa_pkg::PTS_W-1:0]     em_points_r;

  logic [SUM_BITS-1:0]            main_sum_r, ref_sum_r, dark_sum_r;
  logic [fsaa_pkg::CNT_W-1:0]     flash_count_r;
  logic [fsaa_pkg::ROW_W-1:0]     row_ref_sum_r;
  logic [fsaa_pkg::PTS_W-1:0]     point_count_r;

  logic [SAMPLE_BITS-1:0]         main_s_r, ref_s_r, dark_s_r;
  logic [SAMPLE_BITS-1:0]         p_main_r, p_ref_r;
  logic                           underflow_r;
  logic                           row_done_r;
  logic [fsaa_pkg::ROW_W-1:0]     div_q_r;
  logic [fsaa_pkg::PTS_W-1:0]     div_rem_r;
  logic [fsaa_pkg::PTS_W-1:0]     div_n_r;
  logic [fsaa_pkg::DIV_CNT_W-1:0] div_cnt_r;

  logic                           out_valid_r;
  logic [fsaa_pkg::OUT_W-1:0]     out_main_r, out_ref_r, out_row_avg_r;
  logic                           out_row_done_r, out_underflow_r;

  logic [ALU_W-1:0]               alu_a, alu_b, alu_res;
  logic                           alu_sub, alu_carry;

  logic                           in_fire;
  logic [fsaa_pkg::CNT_W:0]       flash_done;
  logic [SUM_BITS-1:0]            main_val;
  logic [SHIFT_AMT_W-1:0]         shamt;
  logic [fsaa_pkg::PTS_W:0]       rem_shift;

  assign in_fire    = in_ch.valid & in_ch.ready;
  assign flash_done = {1'b0, flash_count_r} + 1'b1;
  assign shamt      = fsaa_pkg::flash_shift(accum_sel_r);
  assign rem_shift  = {div_rem_r, div_q_r[fsaa_pkg::ROW_W-1]};

  assign sts.in_valid   = in_ch.valid;
  assign sts.dark_en    = dark_en_r;
  assign sts.point_last = flash_done >= fsaa_pkg::flash_target(accum_sel_r);
  assign sts.row_last   = (point_count_r == '0) || (point_count_r >= em_points_r);
  assign sts.div_last   = div_cnt_r == '0;
  assign sts.out_free   = !out_valid_r || out_ch.ready;

  fsaa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    if (ctl.do_main) begin
      alu_a = ALU_W'(main_sum_r);
      alu_b = ALU_W'(main_s_r);
    end else if (ctl.do_ref) begin
      alu_a = ALU_W'(ref_sum_r);
      alu_b = ALU_W'(ref_s_r);
    end else if (ctl.do_dark) begin
      alu_a = ALU_W'(dark_sum_r);
      alu_b = ALU_W'(dark_s_r);
    end else if (ctl.do_sub) begin
      alu_a   = ALU_W'(main_sum_r);
      alu_b   = ALU_W'(dark_sum_r);
      alu_sub = 1'b1;
    end else if (ctl.do_row) begin
      alu_a = ALU_W'(row_ref_sum_r);
      alu_b = ALU_W'(p_ref_r);
    end else if (ctl.do_div) begin
      alu_a   = ALU_W'(rem_shift);
      alu_b   = ALU_W'(div_n_r);
      alu_sub = 1'b1;
    end
  end

  fsaa_alu #(.W(ALU_W)) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .res   (alu_res),
    .carry (alu_carry)
  );

  always_comb begin
    if (!dark_en_r) begin
      main_val = main_sum_r;
    end else if (alu_carry) begin
      main_val = '0;
    end else begin
      main_val = alu_res[SUM_BITS-1:0];
    end
  end

  // configuration and run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_sel_r   <= '0;
      dark_en_r     <= 1'b0;
      em_points_r   <= fsaa_pkg::PTS_W'(1);
      main_sum_r    <= '0;
      ref_sum_r     <= '0;
      dark_sum_r    <= '0;
      flash_count_r <= '0;
      row_ref_sum_r <= '0;
      point_count_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          fsaa_pkg::CFG_ACCUM_SELECT: accum_sel_r <= cfg_wdata[fsaa_pkg::SEL_W-1:0];
          fsaa_pkg::CFG_DARK_ENABLE:  dark_en_r   <= cfg_wdata[0];
          fsaa_pkg::CFG_EM_POINTS:    em_points_r <= cfg_wdata[fsaa_pkg::PTS_W-1:0];
          default: ;
        endcase
      end
      if (in_fire && in_ch.restart) begin
        main_sum_r    <= '0;
        ref_sum_r     <= '0;
        dark_sum_r    <= '0;
        flash_count_r <= '0;
        row_ref_sum_r <= '0;
        point_count_r <= '0;
      end
      if (ctl.do_main) main_sum_r <= alu_res[SUM_BITS-1:0];
      if (ctl.do_ref)  ref_sum_r  <= alu_res[SUM_BITS-1:0];
      if (ctl.do_dark) dark_sum_r <= alu_res[SUM_BITS-1:0];
      if (ctl.do_count && !sts.point_last) begin
        flash_count_r <= flash_done[fsaa_pkg::CNT_W-1:0];
      end
      if (ctl.do_sub) begin
        main_sum_r    <= '0;
        ref_sum_r     <= '0;
        dark_sum_r    <= '0;
        flash_count_r <= '0;
        point_count_r <= point_count_r + 1'b1;
      end
      if (ctl.do_row) begin
        if (sts.row_last) begin
          row_ref_sum_r <= '0;
          point_count_r <= '0;
        end else begin
          row_ref_sum_r <= alu_res[fsaa_pkg::ROW_W-1:0];
        end
      end
    end
  end

  // samples, point results and divider
  always_ff @(posedge clk) begin
    if (in_fire) begin
      main_s_r <= {~in_ch.main_raw[SAMPLE_BITS-1], in_ch.main_raw[SAMPLE_BITS-2:0]};
      ref_s_r  <= {~in_ch.ref_raw[SAMPLE_BITS-1], in_ch.ref_raw[SAMPLE_BITS-2:0]};
      dark_s_r <= {~in_ch.dark_raw[SAMPLE_BITS-1], in_ch.dark_raw[SAMPLE_BITS-2:0]};
    end
    if (ctl.do_sub) begin
      p_main_r    <= SAMPLE_BITS'(main_val >> shamt);
      p_ref_r     <= SAMPLE_BITS'(ref_sum_r >> shamt);
      underflow_r <= dark_en_r & alu_carry;
    end
    if (ctl.do_row) begin
      row_done_r <= sts.row_last;
      div_q_r    <= alu_res[fsaa_pkg::ROW_W-1:0];
      div_rem_r  <= '0;
      div_cnt_r  <= fsaa_pkg::DIV_CNT_W'(fsaa_pkg::DIV_STEPS - 1);
      div_n_r    <= (point_count_r == '0) ? fsaa_pkg::PTS_W'(1) : point_count_r;
    end
    if (ctl.do_div) begin
      div_rem_r <= alu_carry ? rem_shift[fsaa_pkg::PTS_W-1:0]
                             : alu_res[fsaa_pkg::PTS_W-1:0];
      div_q_r   <= {div_q_r[fsaa_pkg::ROW_W-2:0], ~alu_carry};
      div_cnt_r <= div_cnt_r - 1'b1;
    end
    if (ctl.do_out) begin
      out_main_r      <= fsaa_pkg::OUT_W'(p_main_r);
      out_ref_r       <= fsaa_pkg::OUT_W'(p_ref_r);
      out_row_done_r  <= row_done_r;
      out_row_avg_r   <= row_done_r ? div_q_r[fsaa_pkg::OUT_W-1:0] : '0;
      out_underflow_r <= underflow_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.do_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_ch.ready           = ctl.in_ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.point_main     = out_main_r;
  assign out_ch.point_ref      = out_ref_r;
  assign out_ch.row_done       = out_row_done_r;
  assign out_ch.row_ref_avg    = out_row_avg_r;
  assign out_ch.main_underflow = out_underflow_r;

  `FSAA_ASSERT(a_busy_after_accept, clk, rst_n, in_fire |=> !in_ch.ready, "ready after accept")
  `FSAA_ASSERT(a_underflow_zero, clk, rst_n, out_ch.valid && out_ch.main_underflow |-> out_ch.point_main == '0, "underflow with nonzero main")
  `FSAA_ASSERT(a_underflow_dark, clk, rst_n, out_ch.valid && out_ch.main_underflow |-> dark_en_r, "underflow without dark subtraction")
  `FSAA_ASSERT(a_row_avg_zero, clk, rst_n, out_ch.valid && !out_ch.row_done |-> out_ch.row_ref_avg == '0, "row average outside row end")
  `FSAA_ASSERT_NR(a_reset_clears_out, clk, !rst_n |=> !out_ch.valid, "result valid after reset")

endmodule
